/* hw/rtl/u16to8_pkg.sv */
// ----------------------------------------------------------------------------
// u16to8_pkg
// Shared types and constants of the UTF-16 to UTF-8 encoder.
// ----------------------------------------------------------------------------
package u16to8_pkg;

  localparam int UNIT_W  = 16;
  localparam int BYTE_W  = 8;
  localparam int COUNT_W = 16;
  localparam int CAP_W   = 16;
  localparam int OFFS_W  = 11;

  // Reset value of the capacity register
  localparam logic [CAP_W-1:0] CAP_RESET = 16'd256;

  // Code unit classes
  localparam logic [UNIT_W-1:0] ONE_BYTE_LIMIT = 16'h0080;
  localparam logic [UNIT_W-1:0] TWO_BYTE_LIMIT = 16'h0800;
  localparam logic [4:0]        SURR_TAG       = 5'b11011;  // D800..DFFF

  // Surrogate join arithmetic (32-bit wrap)
  localparam logic [31:0] LOW_SURR_BASE = 32'h0000_DC00;
  localparam logic [31:0] SUPP_BASE     = 32'h0001_0000;

  // UTF-8 byte prefixes
  localparam logic [BYTE_W-1:0] PFX_FOUR = 8'hF0;
  localparam logic [BYTE_W-1:0] PFX_THREE = 8'hE0;
  localparam logic [BYTE_W-1:0] PFX_TWO  = 8'hC0;
  localparam logic [BYTE_W-1:0] PFX_CONT = 8'h80;
  localparam logic [BYTE_W-1:0] TERM_BYTE = 8'h00;

  // One queued run of bytes caused by one code unit
  typedef struct packed {
    logic [1:0]                   last_idx;   // number of bytes minus one
    logic [3:0][BYTE_W-1:0]       bytes;      // index 0 goes out first
    logic                         string_end;
    logic [COUNT_W-1:0]           byte_count;
  } u16to8_entry_t;

endpackage

/* hw/rtl/u16to8_if.sv */
// ----------------------------------------------------------------------------
// u16to8 interfaces
// Valid/ready channels for code units, output bytes and the capacity write.
// ----------------------------------------------------------------------------
interface u16to8_unit_if import u16to8_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [UNIT_W-1:0] code_unit;
  modport source (output valid, output code_unit, input ready);
  modport sink   (input valid, input code_unit, output ready);
endinterface

interface u16to8_byte_if import u16to8_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [BYTE_W-1:0]  out_byte;
  logic               run_last;
  logic               string_end;
  logic [COUNT_W-1:0] byte_count;
  modport source (output valid, output out_byte, output run_last,
                  output string_end, output byte_count, input ready);
  modport sink   (input valid, input out_byte, input run_last,
                  input string_end, input byte_count, output ready);
endinterface

interface u16to8_cfg_if import u16to8_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] capacity;
  modport source (output valid, output capacity, input ready);
  modport sink   (input valid, input capacity, output ready);
endinterface

/* hw/rtl/utf16_to_utf8_encoder.sv */
// ----------------------------------------------------------------------------
// utf16_to_utf8_encoder
// Streaming UTF-16 to UTF-8 encoder with a capacity limit per string.
// ----------------------------------------------------------------------------
// Channels: in_if takes one UTF-16 code unit per item; a zero unit ends the
// string. out_if gives one UTF-8 byte per item, with run_last on the last
// byte of each unit and string_end plus byte_count on the terminator byte.
// cfg_if writes the capacity (bytes, terminator included); it is always
// ready and should be written only while the block is idle.
// Path: a unit's bytes are written to the run queue at acceptance, then
// loaded one by one into the output register once it is free.
// Throughput: the output gives one byte per cycle while the receiver is
// ready and the queue holds bytes; a run holds 1 to 4 bytes (4 for a
// surrogate pair). Units are taken every cycle while the queue has room,
// also those that make no byte; in_if.ready drops only when the run queue
// (QUEUE_DEPTH entries) is full.
// Reset: capacity returns to 256, string state, queue and output clear.
// Receiver stall: the output register holds its byte, the queue fills, and
// then the input side stalls.
// ----------------------------------------------------------------------------
module utf16_to_utf8_encoder import u16to8_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  u16to8_unit_if.sink   in_if,
  u16to8_byte_if.source out_if,
  u16to8_cfg_if.sink    cfg_if
);

  logic          q_full, q_push, q_pop, q_not_empty;
  u16to8_entry_t q_in, q_head;

  u16to8_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_if),
    .cfg_if  (cfg_if),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_entry (q_in)
  );

  u16to8_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .head       (q_head),
    .not_empty  (q_not_empty)
  );

  u16to8_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .head_valid (q_not_empty),
    .pop        (q_pop),
    .out_if     (out_if)
  );

endmodule

/* hw/rtl/u16to8_front.sv */
// ----------------------------------------------------------------------------
// u16to8_front
// Accepts code units, tracks string state and room, builds byte runs.
// ----------------------------------------------------------------------------
module u16to8_front import u16to8_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  u16to8_unit_if.sink          in_if,
  u16to8_cfg_if.sink           cfg_if,
  input  logic                 q_full,
  output logic                 q_push,
  output u16to8_entry_t        q_entry
);

  logic [CAP_W-1:0]   capacity_r;
  logic [COUNT_W-1:0] written_count_r, written_count_nxt;
  logic               stopped_r, stopped_nxt;
  logic               lead_pending_r, lead_pending_nxt;
  logic [OFFS_W-1:0]  lead_offset_r, lead_offset_nxt;

  logic               accept;
  logic [UNIT_W-1:0]  c;
  logic [COUNT_W-1:0] room;
  logic [COUNT_W:0]   wc_ext;
  logic [COUNT_W:0]   room_ext;
  logic [31:0]        full;
  logic               produce;
  u16to8_entry_t      entry;

  assign in_if.ready  = !q_full;
  assign cfg_if.ready = 1'b1;
  assign accept       = in_if.valid && in_if.ready;
  assign c            = in_if.code_unit;

  // Room left for bytes, one byte kept for the terminator
  assign room     = (capacity_r == '0) ? '0 : capacity_r - 1'b1;
  assign wc_ext   = {1'b0, written_count_r};
  assign room_ext = {1'b0, room};

  // Surrogate join, 32-bit wrap
  assign full = (({21'b0, lead_offset_r} << 10) | ({16'b0, c} - LOW_SURR_BASE))
                + SUPP_BASE;

  // Classify unit and build the byte run
  always_comb begin
    written_count_nxt = written_count_r;
    stopped_nxt       = stopped_r;
    lead_pending_nxt  = lead_pending_r;
    lead_offset_nxt   = lead_offset_r;
    produce           = 1'b0;
    entry             = '0;

    if (c == '0) begin
      // terminator; a pending lead is dropped
      produce           = 1'b1;
      entry.last_idx    = 2'd0;
      entry.bytes[0]    = TERM_BYTE;
      entry.string_end  = 1'b1;
      entry.byte_count  = written_count_r;
      written_count_nxt = '0;
      stopped_nxt       = 1'b0;
      lead_pending_nxt  = 1'b0;
      lead_offset_nxt   = '0;
    end else if (lead_pending_r) begin
      // partner of a lead: room was kept already
      produce           = 1'b1;
      entry.last_idx    = 2'd3;
      entry.bytes[0]    = PFX_FOUR | full[25:18];
      entry.bytes[1]    = PFX_CONT | {2'b00, full[17:12]};
      entry.bytes[2]    = PFX_CONT | {2'b00, full[11:6]};
      entry.bytes[3]    = PFX_CONT | {2'b00, full[5:0]};
      written_count_nxt = written_count_r + 16'd4;
      lead_pending_nxt  = 1'b0;
      lead_offset_nxt   = '0;
    end else if (stopped_r || (written_count_r >= room)) begin
      stopped_nxt = 1'b1;
    end else if (c < ONE_BYTE_LIMIT) begin
      produce           = 1'b1;
      entry.last_idx    = 2'd0;
      entry.bytes[0]    = c[7:0];
      written_count_nxt = written_count_r + 16'd1;
    end else if (c < TWO_BYTE_LIMIT) begin
      if (wc_ext + 17'd2 > room_ext) begin
        stopped_nxt = 1'b1;
      end else begin
        produce           = 1'b1;
        entry.last_idx    = 2'd1;
        entry.bytes[0]    = PFX_TWO | {3'b000, c[10:6]};
        entry.bytes[1]    = PFX_CONT | {2'b00, c[5:0]};
        written_count_nxt = written_count_r + 16'd2;
      end
    end else if (c[15:11] == SURR_TAG) begin
      // lead held without validation; needs room for 4 bytes
      if (wc_ext + 17'd4 > room_ext) begin
        stopped_nxt = 1'b1;
      end else begin
        lead_pending_nxt = 1'b1;
        lead_offset_nxt  = c[10:0];
      end
    end else begin
      if (wc_ext + 17'd3 > room_ext) begin
        stopped_nxt = 1'b1;
      end else begin
        produce           = 1'b1;
        entry.last_idx    = 2'd2;
        entry.bytes[0]    = PFX_THREE | {4'b0000, c[15:12]};
        entry.bytes[1]    = PFX_CONT | {2'b00, c[11:6]};
        entry.bytes[2]    = PFX_CONT | {2'b00, c[5:0]};
        written_count_nxt = written_count_r + 16'd3;
      end
    end
  end

  assign q_push  = accept && produce;
  assign q_entry = entry;

  // String state and capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r      <= CAP_RESET;
      written_count_r <= '0;
      stopped_r       <= 1'b0;
      lead_pending_r  <= 1'b0;
      lead_offset_r   <= '0;
    end else begin
      if (cfg_if.valid && cfg_if.ready) begin
        capacity_r <= cfg_if.capacity;
      end
      if (accept) begin
        written_count_r <= written_count_nxt;
        stopped_r       <= stopped_nxt;
        lead_pending_r  <= lead_pending_nxt;
        lead_offset_r   <= lead_offset_nxt;
      end
    end
  end

endmodule

/* hw/rtl/u16to8_fifo.sv */
// ----------------------------------------------------------------------------
// u16to8_fifo
// Short queue of byte runs between the front and the back.
// ----------------------------------------------------------------------------
module u16to8_fifo import u16to8_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  u16to8_entry_t push_entry,
  output logic          full,
  input  logic          pop,
  output u16to8_entry_t head,
  output logic          not_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  u16to8_entry_t      slots_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   count_r;
  logic               do_push, do_pop;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = slots_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_entry;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

/* hw/rtl/u16to8_back.sv */
// ----------------------------------------------------------------------------
// u16to8_back
// Sends queued runs out via an output register, one byte per cycle when ready.
// ----------------------------------------------------------------------------
module u16to8_back import u16to8_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  u16to8_entry_t head,
  input  logic          head_valid,
  output logic          pop,
  u16to8_byte_if.source out_if
);

  logic [1:0]         idx_r;
  logic               out_valid_r;
  logic [BYTE_W-1:0]  out_byte_r;
  logic               run_last_r;
  logic               string_end_r;
  logic [COUNT_W-1:0] byte_count_r;
  logic               load;
  logic               at_last;

  assign load    = head_valid && (!out_valid_r || out_if.ready);
  assign at_last = (idx_r == head.last_idx);
  assign pop     = load && at_last;

  assign out_if.valid      = out_valid_r;
  assign out_if.out_byte   = out_byte_r;
  assign out_if.run_last   = run_last_r;
  assign out_if.string_end = string_end_r;
  assign out_if.byte_count = byte_count_r;

  // Byte index and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        idx_r       <= at_last ? 2'd0 : idx_r + 2'd1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r   <= head.bytes[idx_r];
      run_last_r   <= at_last;
      string_end_r <= head.string_end;
      byte_count_r <= head.byte_count;
    end
  end

endmodule
